FILE: design/soft_binned_smoothed_histogram_defines.svh
// ---------------------------------------------------------------------------
// Soft-binned histogram assertion macros
// Shared property forms for the checker of the histogram block.
// ---------------------------------------------------------------------------
`ifndef SOFT_BINNED_SMOOTHED_HISTOGRAM_DEFINES_SVH
`define SOFT_BINNED_SMOOTHED_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBSH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define SBSH_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sbsh_pkg.sv
// ---------------------------------------------------------------------------
// Soft-binned histogram package
// Widths, register indexes, tap weights and the control interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package sbsh_pkg;

  localparam int MAX_BINS_DEF   = 64;
  localparam int TAPS_DEF       = 5;
  localparam int COUNT_BITS_DEF = 20;

  localparam int SAMPLE_W = 17;
  localparam int NB_W     = 7;
  localparam int IDX_W    = 6;
  localparam int VAL_W    = 36;
  localparam int WT_W     = 17;
  localparam int WSUM_W   = 19;
  localparam int ACC_W    = 56;
  localparam int LO_W     = 18;
  localparam int HI_W     = VAL_W - LO_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 1'b1;

  localparam logic [SAMPLE_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [SAMPLE_W-1:0] HALF_Q16     = 17'h08000;
  localparam logic [VAL_W-1:0]    VAL_MAX      = '1;
  localparam logic [NB_W-1:0]     NUM_BINS_RST = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic count_inc;
    logic set_drop;
    logic acc_calc;
    logic rd_l;
    logic wr_l;
    logic rd_k;
    logic wr_k;
    logic bin_init;
    logic tap_rd;
    logic tap_next;
    logic mul_lo;
    logic mul_hi;
    logic div_blur;
    logic take_blur;
    logic div_norm;
    logic take_norm;
    logic emit;
    logic bin_next;
    logic fin_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_full;
    logic count_zero;
    logic norm_en;
    logic tap_done;
    logic tap_in_range;
    logic div_done;
    logic out_free;
    logic bin_last;
  } sts_t;

  // Gaussian tap weight in Q1.16 for a tap count and a distance from the center.
  function automatic logic [WT_W-1:0] tap_weight(input int taps, input int tap_off);
    int row;
    int d;
    logic [WT_W-1:0] w;
    row = taps - 3;
    if (row < 0) row = 0;
    if (row > 2) row = 2;
    d = (tap_off < 0) ? -tap_off : tap_off;
    if (d > 2) d = 2;
    w = 17'h10000;
    if (row == 0) begin
      if (d == 1) w = 17'd58644;
      else if (d == 2) w = 17'd42020;
    end else if (row == 1) begin
      if (d == 1) w = 17'd61565;
      else if (d == 2) w = 17'd51039;
    end else begin
      if (d == 1) w = 17'd62966;
      else if (d == 2) w = 17'd55846;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/sbsh_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sbsh_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/sbsh_div.sv
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sbsh_div #(
  parameter int DVW = 56,
  parameter int DSW = 20
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic      [DVW-1:0] quotient,
  output logic                done
);

  localparam int CW = $clog2(DVW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DSW:0]  rem_r;
  logic [DVW-1:0] quo_r;
  logic [DSW-1:0] dsr_r;
  logic [DSW:0]  rem_sh;
  logic [DSW:0]  diff;
  logic          ge;

  assign rem_sh = {rem_r[DSW-1:0], quo_r[DVW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(DVW);
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      rem_r <= ge ? diff : rem_sh;
      quo_r <= {quo_r[DVW-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

FILE: design/sbsh_ctrl.sv
// ---------------------------------------------------------------------------
// Histogram controller
// Sequences sample updates and the per-bin smoothing and emit steps.
// ---------------------------------------------------------------------------
`default_nettype none

module sbsh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_ready,
  input  wire sbsh_pkg::sts_t sts,
  output sbsh_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC_CALC = 4'd1;
  localparam logic [3:0] S_ACC_RD_L = 4'd2;
  localparam logic [3:0] S_ACC_WR_L = 4'd3;
  localparam logic [3:0] S_ACC_RD_K = 4'd4;
  localparam logic [3:0] S_ACC_WR_K = 4'd5;
  localparam logic [3:0] S_FIN_TAP  = 4'd6;
  localparam logic [3:0] S_FIN_MLO  = 4'd7;
  localparam logic [3:0] S_FIN_MHI  = 4'd8;
  localparam logic [3:0] S_FIN_DIV1 = 4'd9;
  localparam logic [3:0] S_FIN_NORM = 4'd10;
  localparam logic [3:0] S_FIN_DIV2 = 4'd11;
  localparam logic [3:0] S_FIN_EMIT = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind) begin
            cmd.bin_init = 1'b1;
            state_nxt    = S_FIN_TAP;
          end else if (sts.count_full) begin
            cmd.set_drop = 1'b1;
          end else begin
            cmd.count_inc = 1'b1;
            state_nxt     = S_ACC_CALC;
          end
        end
      end
      S_ACC_CALC: begin
        cmd.acc_calc = 1'b1;
        state_nxt    = S_ACC_RD_L;
      end
      S_ACC_RD_L: begin
        cmd.rd_l  = 1'b1;
        state_nxt = S_ACC_WR_L;
      end
      S_ACC_WR_L: begin
        cmd.wr_l  = 1'b1;
        state_nxt = S_ACC_RD_K;
      end
      S_ACC_RD_K: begin
        cmd.rd_k  = 1'b1;
        state_nxt = S_ACC_WR_K;
      end
      S_ACC_WR_K: begin
        cmd.wr_k  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FIN_TAP: begin
        if (sts.tap_done) begin
          cmd.div_blur = 1'b1;
          state_nxt    = S_FIN_DIV1;
        end else if (sts.tap_in_range) begin
          cmd.tap_rd = 1'b1;
          state_nxt  = S_FIN_MLO;
        end else begin
          cmd.tap_next = 1'b1;
        end
      end
      S_FIN_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_FIN_MHI;
      end
      S_FIN_MHI: begin
        cmd.mul_hi   = 1'b1;
        cmd.tap_next = 1'b1;
        state_nxt    = S_FIN_TAP;
      end
      S_FIN_DIV1: begin
        if (sts.div_done) begin
          cmd.take_blur = 1'b1;
          state_nxt = (sts.norm_en && !sts.count_zero) ? S_FIN_NORM : S_FIN_EMIT;
        end
      end
      S_FIN_NORM: begin
        cmd.div_norm = 1'b1;
        state_nxt    = S_FIN_DIV2;
      end
      S_FIN_DIV2: begin
        if (sts.div_done) begin
          cmd.take_norm = 1'b1;
          state_nxt     = S_FIN_EMIT;
        end
      end
      S_FIN_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.bin_last) begin
            cmd.fin_clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.bin_next = 1'b1;
            state_nxt    = S_FIN_TAP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/sbsh_dp.sv
// ---------------------------------------------------------------------------
// Histogram datapath
// Bin memory, sample arithmetic, tap multiply-accumulate, divider and output.
// ---------------------------------------------------------------------------
`default_nettype none

module sbsh_dp #(
  parameter int MAX_BINS   = sbsh_pkg::MAX_BINS_DEF,
  parameter int TAPS       = sbsh_pkg::TAPS_DEF,
  parameter int COUNT_BITS = sbsh_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sbsh_pkg::cmd_t                    cmd,
  output sbsh_pkg::sts_t                         sts,
  input  wire logic [sbsh_pkg::SAMPLE_W-1:0]     in_sample_value,
  input  wire logic                              cfg_we,
  input  wire logic [sbsh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sbsh_pkg::NB_W-1:0]         cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [sbsh_pkg::IDX_W-1:0]        out_bin_index,
  output logic      [sbsh_pkg::VAL_W-1:0]        out_bin_value,
  output logic      [sbsh_pkg::VAL_W-1:0]        out_cumulative_value,
  output logic                                   out_overflow,
  output logic                                   out_last
);

  localparam int SW   = sbsh_pkg::SAMPLE_W;
  localparam int VW   = sbsh_pkg::VAL_W;
  localparam int AW   = $clog2(MAX_BINS);
  localparam int NBW  = $clog2(MAX_BINS + 1);
  localparam int HALF = TAPS / 2;
  localparam int JW   = $clog2(TAPS + 1);
  localparam int TIW  = AW + JW + 1;
  localparam int PW   = SW + NBW;
  localparam int DSW  = (sbsh_pkg::WSUM_W > COUNT_BITS) ? sbsh_pkg::WSUM_W : COUNT_BITS;
  localparam int MPW  = sbsh_pkg::LO_W + sbsh_pkg::WT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  // Configuration.
  logic [sbsh_pkg::NB_W-1:0] num_bins_r;
  logic                      norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= sbsh_pkg::NUM_BINS_RST;
      norm_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbsh_pkg::CFG_NUM_BINS:  num_bins_r <= cfg_data;
        sbsh_pkg::CFG_NORMALIZE: norm_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [NBW-1:0] nb;
  logic [AW-1:0]  nb_m1;

  always_comb begin
    if (num_bins_r == '0) begin
      nb = NBW'(1);
    end else if (num_bins_r > sbsh_pkg::NB_W'(MAX_BINS)) begin
      nb = NBW'(MAX_BINS);
    end else begin
      nb = NBW'(num_bins_r);
    end
  end
  assign nb_m1 = AW'(nb - NBW'(1));

  // Sample count and drop flag.
  logic [COUNT_BITS-1:0] count_r;
  logic                  drop_r;
  logic [MAX_BINS-1:0]   valid_r;

  // Sample arithmetic.
  logic [SW-1:0] samp_r;
  logic [SW-1:0] v;
  logic [PW-1:0] p;
  logic [NBW:0]  kraw;
  logic [AW-1:0] k;
  logic [AW-1:0] l;
  logic [SW-1:0] f;
  logic [SW-1:0] ad;
  logic [AW-1:0] k_r;
  logic [AW-1:0] l_r;
  logic [SW-1:0] ad_r;

  always_comb begin
    v    = (samp_r > sbsh_pkg::ONE_Q16) ? sbsh_pkg::ONE_Q16 : samp_r;
    p    = PW'(v) * PW'(nb);
    kraw = p[PW-1:16];
    k    = (kraw > (NBW + 1)'(nb_m1)) ? nb_m1 : kraw[AW-1:0];
    f    = SW'(p - (PW'(k) << 16));
    if (f > sbsh_pkg::HALF_Q16) begin
      ad = f - sbsh_pkg::HALF_Q16;
      l  = (k == nb_m1) ? nb_m1 : k + AW'(1);
    end else begin
      ad = sbsh_pkg::HALF_Q16 - f;
      l  = (k == '0) ? '0 : k - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= in_sample_value;
    end
    if (cmd.acc_calc) begin
      k_r  <= k;
      l_r  <= l;
      ad_r <= ad;
    end
  end

  // Finish loop registers.
  logic [AW-1:0]               bin_r;
  logic [JW-1:0]               j_r;
  logic [sbsh_pkg::ACC_W-1:0]  acc_r;
  logic [sbsh_pkg::WSUM_W-1:0] wsum_r;
  logic [sbsh_pkg::HI_W-1:0]   hi_r;
  logic [VW-1:0]               val_r;
  logic [VW-1:0]               cum_r;
  logic signed [TIW-1:0]       ti;
  logic                        ti_ok;
  logic [sbsh_pkg::WT_W-1:0]   wt;

  assign ti    = $signed(TIW'(bin_r)) + $signed(TIW'(j_r)) - $signed(TIW'(HALF));
  assign ti_ok = (ti >= 0) && (ti < $signed(TIW'(nb)));
  assign wt    = sbsh_pkg::tap_weight(TAPS, int'(j_r) - HALF);

  // Bin memory with per-entry valid bits: an unwritten entry reads as zero.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;
  logic          rd_valid_r;
  logic [VW-1:0] eff;
  logic [SW-1:0] addend;
  logic [VW:0]   wsum_sat;

  always_comb begin
    if (cmd.rd_l) begin
      ram_raddr = l_r;
    end else if (cmd.rd_k) begin
      ram_raddr = k_r;
    end else begin
      ram_raddr = ti[AW-1:0];
    end
  end

  assign eff       = rd_valid_r ? ram_rdata : '0;
  assign ram_we    = cmd.wr_l | cmd.wr_k;
  assign ram_waddr = cmd.wr_l ? l_r : k_r;
  assign addend    = cmd.wr_l ? ad_r : sbsh_pkg::ONE_Q16 - ad_r;
  assign wsum_sat  = {1'b0, eff} + (VW + 1)'(addend);
  assign ram_wdata = wsum_sat[VW] ? sbsh_pkg::VAL_MAX : wsum_sat[VW-1:0];

  sbsh_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.fin_clear) begin
        valid_r <= '0;
        count_r <= '0;
        drop_r  <= 1'b0;
      end else begin
        if (ram_we) begin
          valid_r[ram_waddr] <= 1'b1;
        end
        if (cmd.count_inc) begin
          count_r <= count_r + COUNT_BITS'(1);
        end
        if (cmd.set_drop) begin
          drop_r <= 1'b1;
        end
      end
    end
  end

  // Shared multiplier: low half of the bin, then high half.
  logic [sbsh_pkg::LO_W-1:0] mul_a;
  logic [MPW-1:0]            mprod;

  assign mul_a = cmd.mul_hi ? sbsh_pkg::LO_W'(hi_r) : eff[sbsh_pkg::LO_W-1:0];
  assign mprod = MPW'(mul_a) * MPW'(wt);

  // Divider.
  logic                       div_start;
  logic [sbsh_pkg::ACC_W-1:0] div_dvd;
  logic [DSW-1:0]             div_dsr;
  logic [sbsh_pkg::ACC_W-1:0] div_quo;
  logic                       div_done;
  logic [VW-1:0]              quo_sat;

  assign div_start = cmd.div_blur | cmd.div_norm;
  assign div_dvd   = cmd.div_blur
                     ? acc_r + sbsh_pkg::ACC_W'(wsum_r >> 1)
                     : sbsh_pkg::ACC_W'(val_r) + sbsh_pkg::ACC_W'(count_r >> 1);
  assign div_dsr   = cmd.div_blur ? DSW'(wsum_r) : DSW'(count_r);
  assign quo_sat   = (|div_quo[sbsh_pkg::ACC_W-1:VW]) ? sbsh_pkg::VAL_MAX : div_quo[VW-1:0];

  sbsh_div #(
    .DVW (sbsh_pkg::ACC_W),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Cumulative sum, saturating.
  logic [VW:0]   csum;
  logic [VW-1:0] cnew;

  assign csum = {1'b0, cum_r} + {1'b0, val_r};
  assign cnew = csum[VW] ? sbsh_pkg::VAL_MAX : csum[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.bin_init || cmd.bin_next) begin
      bin_r  <= cmd.bin_init ? '0 : bin_r + AW'(1);
      j_r    <= '0;
      acc_r  <= '0;
      wsum_r <= '0;
    end else begin
      if (cmd.tap_next) begin
        j_r <= j_r + JW'(1);
      end
      if (cmd.mul_lo) begin
        acc_r <= acc_r + sbsh_pkg::ACC_W'(mprod);
        hi_r  <= eff[VW-1:sbsh_pkg::LO_W];
      end
      if (cmd.mul_hi) begin
        acc_r  <= acc_r + (sbsh_pkg::ACC_W'(mprod) << sbsh_pkg::LO_W);
        wsum_r <= wsum_r + sbsh_pkg::WSUM_W'(wt);
      end
    end
    if (cmd.bin_init) begin
      cum_r <= '0;
    end else if (cmd.emit) begin
      cum_r <= cnew;
    end
    if (cmd.take_blur) begin
      val_r <= (norm_r && count_r == '0) ? '0 : quo_sat;
    end else if (cmd.take_norm) begin
      val_r <= quo_sat;
    end
  end

  // Output register.
  logic                      out_valid_r;
  logic [sbsh_pkg::IDX_W-1:0] out_idx_r;
  logic [VW-1:0]             out_val_r;
  logic [VW-1:0]             out_cum_r;
  logic                      out_ovf_r;
  logic                      out_last_r;
  logic                      bin_last;

  assign bin_last = (bin_r == nb_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= sbsh_pkg::IDX_W'(bin_r);
      out_val_r  <= val_r;
      out_cum_r  <= cnew;
      out_ovf_r  <= drop_r;
      out_last_r <= bin_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_bin_index        = out_idx_r;
  assign out_bin_value        = out_val_r;
  assign out_cumulative_value = out_cum_r;
  assign out_overflow         = out_ovf_r;
  assign out_last             = out_last_r;

  always_comb begin
    sts.count_full   = (count_r == COUNT_LIMIT);
    sts.count_zero   = (count_r == '0);
    sts.norm_en      = norm_r;
    sts.tap_done     = (j_r == JW'(TAPS));
    sts.tap_in_range = ti_ok;
    sts.div_done     = div_done;
    sts.out_free     = !out_valid_r || out_ready;
    sts.bin_last     = bin_last;
  end

endmodule

`default_nettype wire

FILE: design/soft_binned_smoothed_histogram.sv
// ---------------------------------------------------------------------------
// Soft-binned smoothed histogram
// Linear-interpolated histogram with Gaussian smoothing and cumulative output.
// ---------------------------------------------------------------------------
// A sample transaction (in_kind = 0) spreads a Q1.16 value over the two
// nearest bins; before the next transaction is accepted, the block runs the
// address calculation and two read-modify-write passes over the bin memory.
// A finish transaction (in_kind = 1) smooths every bin in use and returns
// one result transaction per bin, the final one marked by out_last, and then
// clears the bins, the sample count and the drop flag. For each bin of a
// finish, each tap inside the bins in use is read, and its low and high
// halves are weighted and accumulated, while a tap outside them is skipped;
// then come the weighted-average division (56 quotient bits at one per
// cycle, a step to start and a step to take the result), a second division
// when normalize_enable is set with a nonzero count, and the hand-over of
// the bin to the output register, which waits while that register is still
// occupied; the shared one-bit-per-cycle divider dominates this work. Only
// one transaction is in work at a time, and in_ready is high while the block
// is idle; a finished result sits in the output register and the block goes
// on with the next bin (or accepts the next transaction) while it waits to
// be taken. Configuration writes must be made while the block is idle.
// Samples that arrive once the count has reached its limit are dropped and
// out_overflow reports it on every result of the following finish.

`default_nettype none

module soft_binned_smoothed_histogram #(
  parameter int MAX_BINS   = sbsh_pkg::MAX_BINS_DEF,
  parameter int TAPS       = sbsh_pkg::TAPS_DEF,
  parameter int COUNT_BITS = sbsh_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_kind,
  input  wire logic [sbsh_pkg::SAMPLE_W-1:0]  in_sample_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sbsh_pkg::IDX_W-1:0]     out_bin_index,
  output logic      [sbsh_pkg::VAL_W-1:0]     out_bin_value,
  output logic      [sbsh_pkg::VAL_W-1:0]     out_cumulative_value,
  output logic                                out_overflow,
  output logic                                out_last,
  input  wire logic                           cfg_we,
  input  wire logic [sbsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbsh_pkg::NB_W-1:0]      cfg_data
);

  // The controller only sequences; every register of the data lives in the
  // datapath, and the two talk through the command and status structs.
  sbsh_pkg::cmd_t cmd;
  sbsh_pkg::sts_t sts;

  sbsh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbsh_dp #(
    .MAX_BINS   (MAX_BINS),
    .TAPS       (TAPS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_sample_value      (in_sample_value),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_bin_index        (out_bin_index),
    .out_bin_value        (out_bin_value),
    .out_cumulative_value (out_cumulative_value),
    .out_overflow         (out_overflow),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

FILE: design/sbsh_checker.sv
// ---------------------------------------------------------------------------
// Histogram port checker
// Watches the result channel of the histogram block over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "soft_binned_smoothed_histogram_defines.svh"

module sbsh_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sbsh_pkg::IDX_W-1:0] out_bin_index,
  input wire logic [sbsh_pkg::VAL_W-1:0] out_bin_value,
  input wire logic [sbsh_pkg::VAL_W-1:0] out_cumulative_value,
  input wire logic                       out_overflow,
  input wire logic                       out_last
);

  localparam int BUNDLE_W = sbsh_pkg::IDX_W + 2 * sbsh_pkg::VAL_W + 2;

  // All result fields side by side, so that one stability check covers them.
  logic [BUNDLE_W-1:0] out_bundle;

  assign out_bundle = {out_bin_index, out_bin_value, out_cumulative_value,
                       out_overflow, out_last};

  // A stalled result holds.
  `SBSH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bundle), "stalled result changed")

  // No result is pending right after reset.
  `SBSH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "result valid after reset")

  // The running sum never falls below the bin it includes.
  `SBSH_ASSERT_SAME(a_cum_ge, clk, rst_n, out_valid, out_cumulative_value >= out_bin_value, "cumulative below bin value")

  // The first bin of a run starts the running sum afresh.
  `SBSH_ASSERT_SAME(a_cum_first, clk, rst_n, out_valid && out_bin_index == '0, out_cumulative_value == out_bin_value, "cumulative not restarted")

endmodule

bind soft_binned_smoothed_histogram sbsh_checker u_sbsh_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// Soft-binned smoothed histogram testbench
// Drives samples and finish transactions with bursty input and a stalling
// output, predicts every emitted bin, and checks each result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W  = sbsh_pkg::SAMPLE_W;
  localparam int VAL_W     = sbsh_pkg::VAL_W;
  localparam int IDX_W     = sbsh_pkg::IDX_W;
  localparam int NB_W      = sbsh_pkg::NB_W;
  localparam int CFG_IDX_W = sbsh_pkg::CFG_IDX_W;
  localparam int TAPS      = sbsh_pkg::TAPS_DEF;

  // Kinds of row in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_FINISH,
    ROW_SET_BINS,
    ROW_SET_NORM
  } row_op_t;

  typedef struct {
    row_op_t            op;
    logic [SAMPLE_W-1:0] arg;
    bit                 typed;  // The bin value of every result is typed in.
    logic [VAL_W-1:0]   typed_value;
  } stim_row_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] cumulative;
    logic             overflow;
    logic             last;
  } bin_result_t;

  localparam int NBINS       = sbsh_pkg::MAX_BINS_DEF;
  localparam int CNT_BITS    = sbsh_pkg::COUNT_BITS_DEF;
  localparam int HALF_TAPS   = TAPS / 2;
  localparam int RANDOM_ITEMS = 290;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [VAL_W-1:0] SAT36 = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [SAMPLE_W-1:0] in_sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_bin_index;
  logic [VAL_W-1:0] out_bin_value;
  logic [VAL_W-1:0] out_cumulative_value;
  logic out_overflow;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = sbsh_pkg::CFG_NUM_BINS;
  logic [NB_W-1:0] cfg_data = '0;

  soft_binned_smoothed_histogram dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bin_index(out_bin_index),
    .out_bin_value(out_bin_value),
    .out_cumulative_value(out_cumulative_value),
    .out_overflow(out_overflow),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow state of the histogram: bin accumulators, sample count, drop flag
  // and the two configuration registers.
  logic [VAL_W-1:0]    shadow_bins [NBINS];
  logic [CNT_BITS-1:0] shadow_count;
  logic                shadow_dropped;
  logic [NB_W-1:0]     shadow_num_bins;
  logic                shadow_normalize;

  bin_result_t expected_bins[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;
  int burst_left = 0;

  // Gaussian weight of a tap at a given distance from the center, TAPS = 5.
  function automatic longint unsigned gauss_weight(input int tap_off);
    int d;
    d = (tap_off < 0) ? -tap_off : tap_off;
    if (d == 0) return 64'd65536;
    if (d == 1) return 64'd62966;
    return 64'd55846;
  endfunction

  function automatic int bins_active();
    if (shadow_num_bins < 1) return 1;
    if (shadow_num_bins > NBINS) return NBINS;
    return int'(shadow_num_bins);
  endfunction

  function automatic void bump_bin(input int idx, input longint unsigned amount);
    longint unsigned s;
    s = longint'(shadow_bins[idx]) + amount;
    shadow_bins[idx] = (s > longint'(SAT36)) ? SAT36 : s[VAL_W-1:0];
  endfunction

  // A sample spreads its weight over its own bin and the nearer neighbor.
  function automatic void hist_predict_sample(input logic [SAMPLE_W-1:0] raw);
    int nb;
    longint unsigned v, p, f, dist_half;
    int k, l;
    nb = bins_active();
    if (shadow_count == {CNT_BITS{1'b1}}) begin
      shadow_dropped = 1'b1;
      return;
    end
    shadow_count = shadow_count + 1'b1;
    v = (raw > sbsh_pkg::ONE_Q16) ? 64'd65536 : longint'(raw);
    p = v * nb;
    k = int'(p >> 16);
    if (k > nb - 1) k = nb - 1;
    f = p - longint'(k) * 65536;
    if (f > 32768) begin
      dist_half = f - 32768;
      l = (k + 1 > nb - 1) ? nb - 1 : k + 1;
    end else begin
      dist_half = 32768 - f;
      l = (k == 0) ? 0 : k - 1;
    end
    bump_bin(l, dist_half);
    bump_bin(k, 65536 - dist_half);
  endfunction

  // A finish smooths each bin in use, optionally divides by the count, and
  // queues one expected result per bin before clearing the shadow state.
  function automatic void hist_predict_finish();
    int nb, idx;
    longint unsigned blur, wsum, val, cum;
    bin_result_t r;
    nb = bins_active();
    cum = 0;
    for (int i = 0; i < nb; i++) begin
      blur = 0;
      wsum = 0;
      for (int j = 0; j < TAPS; j++) begin
        idx = i - HALF_TAPS + j;
        if (idx >= 0 && idx < nb) begin
          blur += longint'(shadow_bins[idx]) * gauss_weight(j - HALF_TAPS);
          wsum += gauss_weight(j - HALF_TAPS);
        end
      end
      val = (blur + wsum / 2) / wsum;
      if (shadow_normalize) begin
        val = (shadow_count != 0) ?
              (val + shadow_count / 2) / longint'(shadow_count) : 0;
      end
      if (val > longint'(SAT36)) val = SAT36;
      cum += val;
      if (cum > longint'(SAT36)) cum = SAT36;
      r.index = i[IDX_W-1:0];
      r.value = val[VAL_W-1:0];
      r.cumulative = cum[VAL_W-1:0];
      r.overflow = shadow_dropped;
      r.last = (i == nb - 1);
      expected_bins = {expected_bins, r};
    end
    foreach (shadow_bins[b]) shadow_bins[b] = '0;
    shadow_count = '0;
    shadow_dropped = 1'b0;
  endfunction

  // Offers one transaction, honoring the burst and gap pattern of the sender.
  // Valid stays high after acceptance; it is lowered only by a gap or by
  // hist_stop_input, so it never falls and rises in the same time step.
  task automatic hist_send(input logic kind, input logic [SAMPLE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
    if (kind) hist_predict_finish();
    else hist_predict_sample(value);
  endtask

  task automatic hist_stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected bin has arrived and the block has settled.
  task automatic hist_drain();
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic hist_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [NB_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == sbsh_pkg::CFG_NUM_BINS) shadow_num_bins = data;
    else shadow_normalize = data[0];
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
      1: return sbsh_pkg::ONE_Q16;
      2: return sbsh_pkg::HALF_Q16;
      3: return '0;
      default: return SAMPLE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [NB_W-1:0] random_num_bins();
    case ($urandom_range(0, 9))
      0: return NB_W'(64);
      1: return NB_W'(1);
      2: return NB_W'(0);
      3: return NB_W'($urandom_range(65, 127));
      4: return NB_W'($urandom_range(9, 64));
      default: return NB_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Directed rows: extremes of the sample, finish with a junk sample, the
  // empty finish, one bin, zero and oversized bin counts, and normalizing
  // with a zero count.
  stim_row_t directed_rows [] = '{
    '{ROW_FINISH,   17'd0,      1'b1, 36'd0},
    '{ROW_SAMPLE,   17'd0,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'h10000,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'h1FFFF,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'h08000,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd1,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'h0FFFF,  1'b0, 36'd0},
    '{ROW_FINISH,   17'h1FFFF,  1'b0, 36'd0},
    '{ROW_SET_BINS, 17'd1,      1'b0, 36'd0},
    '{ROW_SET_NORM, 17'd1,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'h10000,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd12345,  1'b0, 36'd0},
    '{ROW_FINISH,   17'd0,      1'b1, 36'd65536},
    '{ROW_SET_BINS, 17'd0,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd777,    1'b0, 36'd0},
    '{ROW_FINISH,   17'd0,      1'b1, 36'd65536},
    '{ROW_FINISH,   17'd0,      1'b1, 36'd0},
    '{ROW_SET_BINS, 17'd127,    1'b0, 36'd0},
    '{ROW_SET_NORM, 17'd0,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd40000,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd65535,  1'b0, 36'd0},
    '{ROW_FINISH,   17'd0,      1'b0, 36'd0},
    '{ROW_SET_BINS, 17'd2,      1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd16384,  1'b0, 36'd0},
    '{ROW_SAMPLE,   17'd49152,  1'b0, 36'd0},
    '{ROW_FINISH,   17'd0,      1'b0, 36'd0}
  };

  // The receiver stalls on a pattern whose ready density changes at random
  // intervals. On request it also holds off for a long counted stretch so
  // that the output register fills and the block stalls its input.
  initial begin
    int ready_pct;
    int span;
    ready_pct = 100;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      if (span == 0) begin
        span = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: ready_pct = 100;
          1: ready_pct = 60;
          default: ready_pct = 25;
        endcase
      end
      span--;
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Result checker: every accepted result transaction is compared against
  // the oldest expected bin.
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected result transaction, bin_index %0d", out_bin_index);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (out_bin_index !== want.index) begin
          $error("bin_index expected %0d actual %0d", want.index, out_bin_index);
          errors++;
        end
        if (out_bin_value !== want.value) begin
          $error("bin_value expected %0d actual %0d", want.value, out_bin_value);
          errors++;
        end
        if (out_cumulative_value !== want.cumulative) begin
          $error("cumulative_value expected %0d actual %0d",
                 want.cumulative, out_cumulative_value);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow expected %0d actual %0d", want.overflow, out_overflow);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int items;
    int nsamp;
    int first_len;
    bit pressure_done;
    items = 0;
    pressure_done = 1'b0;
    foreach (shadow_bins[b]) shadow_bins[b] = '0;
    shadow_count = '0;
    shadow_dropped = 1'b0;
    shadow_num_bins = sbsh_pkg::NUM_BINS_RST;
    shadow_normalize = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Register rows first let the block go idle.
    foreach (directed_rows[r]) begin
      case (directed_rows[r].op)
        ROW_SET_BINS, ROW_SET_NORM: begin
          hist_stop_input();
          hist_drain();
          hist_write_reg((directed_rows[r].op == ROW_SET_BINS) ? sbsh_pkg::CFG_NUM_BINS
                         : sbsh_pkg::CFG_NORMALIZE, directed_rows[r].arg[NB_W-1:0]);
        end
        default: begin
          hist_send(directed_rows[r].op == ROW_FINISH, directed_rows[r].arg);
          items++;
          if (directed_rows[r].typed) begin
            // The bins of this finish are the newest entries of the queue.
            first_len = expected_bins.size() - bins_active();
            for (int q = first_len; q < expected_bins.size(); q++) begin
              expected_bins[q].value = directed_rows[r].typed_value;
            end
          end
        end
      endcase
    end

    // Random part: each phase picks a setting, feeds a run of samples and
    // ends with a finish. The first full-size phase carries the long receiver
    // hold-off and is followed by samples without an idle pause.
    while (items < RANDOM_ITEMS + directed_rows.size()) begin
      hist_stop_input();
      hist_drain();
      hist_write_reg(sbsh_pkg::CFG_NUM_BINS, pressure_done ? random_num_bins() : NB_W'(64));
      hist_write_reg(sbsh_pkg::CFG_NORMALIZE, NB_W'($urandom_range(0, 1)));
      nsamp = $urandom_range(0, 24);
      for (int s = 0; s < nsamp; s++) begin
        hist_send(1'b0, random_sample());
        items++;
      end
      if (!pressure_done) hold_request = 1'b1;
      hist_send(1'b1, random_sample());
      items++;
      if (!pressure_done) begin
        pressure_done = 1'b1;
        for (int s = 0; s < 6; s++) begin
          hist_send(1'b0, random_sample());
          items++;
        end
        hist_send(1'b1, '0);
        items++;
      end
    end

    hist_stop_input();
    hist_drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
